// ----- rtl/lslf_pkg.sv -----
// Shared constants, types and the controller/datapath interface for the line-fit core.
package lslf_pkg;

   localparam int MAX_POINTS  = 256;
   localparam int COORD_WIDTH = 16;
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int SUM_W       = 24;
   localparam int SQ_W        = 40;
   localparam int OPER_W      = 64;
   localparam int WIDE_W      = 128;
   localparam int FRAC_SHIFT  = 17;
   localparam int MUL_CNT_W   = $clog2(OPER_W);
   localparam int DIV_CNT_W   = $clog2(WIDE_W);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_X_FLAT   = 2'd1;
   localparam logic [1:0] STATUS_Y_FLAT   = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [31:0] SLOPE_ONE = 32'h0001_0000;
   localparam logic [31:0] Q16_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] Q16_MIN   = 32'h8000_0000;
   localparam logic [16:0] RSQ_ONE   = 17'h1_0000;

   typedef enum logic [3:0] {
      STEP_DX_A,
      STEP_DX_B,
      STEP_DY_A,
      STEP_DY_B,
      STEP_NS_A,
      STEP_NS_B,
      STEP_NI_A,
      STEP_NI_B,
      STEP_R2_NUM,
      STEP_R2_DEN,
      STEP_DIV_SLOPE,
      STEP_DIV_ICPT,
      STEP_DIV_R2
   } step_type;

   typedef struct packed {
      logic     take;
      logic     mul_go;
      logic     div_go;
      logic     finish;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } stat_type;

endpackage

// ----- rtl/lslf_mul.sv -----
// Bit-serial unsigned multiplier, one multiplier bit per clock.
module lslf_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [lslf_pkg::OPER_W-1:0] opa,
   input  logic [lslf_pkg::OPER_W-1:0] opb,
   output logic                        done,
   output logic [lslf_pkg::WIDE_W-1:0] product
);
   import lslf_pkg::*;

   logic                 run_ff;
   logic                 done_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [WIDE_W-1:0]    acc_ff;
   logic [WIDE_W-1:0]    ash_ff;
   logic [OPER_W-1:0]    bsh_ff;
   logic [WIDE_W-1:0]    acc_in;

   assign acc_in = bsh_ff[0] ? acc_ff + ash_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            acc_ff <= '0;
            ash_ff <= {{(WIDE_W-OPER_W){1'b0}}, opa};
            bsh_ff <= opb;
         end else if (run_ff) begin
            acc_ff <= acc_in;
            ash_ff <= ash_ff << 1;
            bsh_ff <= bsh_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(OPER_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- rtl/lslf_div.sv -----
// Restoring divider, one quotient bit per clock.
module lslf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [lslf_pkg::WIDE_W-1:0] dividend,
   input  logic [lslf_pkg::WIDE_W-1:0] divisor,
   output logic                        done,
   output logic [lslf_pkg::WIDE_W-1:0] quotient
);
   import lslf_pkg::*;

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [WIDE_W:0]      rem_ff;
   logic [WIDE_W-1:0]    dvd_ff;
   logic [WIDE_W-1:0]    dsr_ff;
   logic [WIDE_W-1:0]    quo_ff;
   logic [WIDE_W:0]      shifted;
   logic                 fits;

   assign shifted = {rem_ff[WIDE_W-1:0], dvd_ff[WIDE_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= '0;
            dvd_ff <= dividend;
            dsr_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= fits ? shifted - {1'b0, dsr_ff} : shifted;
            quo_ff <= {quo_ff[WIDE_W-2:0], fits};
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(WIDE_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/lslf_datapath.sv -----
// Accumulators, fit registers, shared multiplier and divider, and result registers.
module lslf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lslf_pkg::cmd_type              cmd,
   output lslf_pkg::stat_type             stat,
   input  logic signed [15:0]             req_x,
   input  logic signed [15:0]             req_y,
   output logic signed [31:0]             rsp_slope,
   output logic signed [31:0]             rsp_intercept,
   output logic [16:0]                    rsp_r_squared,
   output logic [1:0]                     rsp_status
);
   import lslf_pkg::*;

   function automatic logic [31:0] q16_sat(input logic [WIDE_W-1:0] q, input logic neg);
      logic [31:0] r;
      if (!neg) begin
         r = (q > WIDE_W'(Q16_MAX)) ? Q16_MAX : q[31:0];
      end else begin
         r = (q > WIDE_W'(Q16_MIN)) ? Q16_MIN : (32'd0 - q[31:0]);
      end
      return r;
   endfunction

   logic [CNT_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0] sx_ff, sy_ff;
   logic signed [SQ_W-1:0]  sxx_ff, syy_ff, sxy_ff;
   logic                    ovf_ff;

   logic signed [OPER_W-1:0] dx_ff, dy_ff, ns_ff, ni_ff;
   logic [WIDE_W-1:0]        r2num_ff, r2den_ff;
   logic [31:0]              slope_ff, icpt_ff;
   logic [16:0]              r2_ff;

   logic [31:0] out_slope_ff, out_icpt_ff;
   logic [16:0] out_r2_ff;
   logic [1:0]  out_status_ff;

   logic signed [COORD_WIDTH-1:0] x, y;
   logic signed [2*COORD_WIDTH-1:0] pxx, pyy, pxy;

   logic signed [OPER_W-1:0] n_e, sx_e, sy_e, sxx_e, syy_e, sxy_e;
   logic signed [OPER_W-1:0] op_a, op_b;
   logic [OPER_W-1:0]        mag_a, mag_b;
   logic                     prod_neg, load;
   logic                     mul_done, div_done;
   logic [WIDE_W-1:0]        product, quotient;
   logic [OPER_W-1:0]        p64;
   logic [WIDE_W-1:0]        div_num, div_den, dividend, divisor;
   logic                     x_flat, y_flat;

   assign x   = req_x;
   assign y   = req_y;
   assign pxx = x * x;
   assign pyy = y * y;
   assign pxy = x * y;

   // Points past the limit are dropped; the flag forces the overflow status.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.finish) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.take) begin
         if (cnt_ff < CNT_W'(MAX_POINTS)) begin
            cnt_ff <= cnt_ff + 1'b1;
            sx_ff  <= sx_ff + SUM_W'(x);
            sy_ff  <= sy_ff + SUM_W'(y);
            sxx_ff <= sxx_ff + SQ_W'(pxx);
            syy_ff <= syy_ff + SQ_W'(pyy);
            sxy_ff <= sxy_ff + SQ_W'(pxy);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   assign n_e   = OPER_W'(cnt_ff);
   assign sx_e  = OPER_W'(sx_ff);
   assign sy_e  = OPER_W'(sy_ff);
   assign sxx_e = OPER_W'(sxx_ff);
   assign syy_e = OPER_W'(syy_ff);
   assign sxy_e = OPER_W'(sxy_ff);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.step)
         STEP_DX_A:   begin op_a = n_e;   op_b = sxx_e; end
         STEP_DX_B:   begin op_a = sx_e;  op_b = sx_e;  end
         STEP_DY_A:   begin op_a = n_e;   op_b = syy_e; end
         STEP_DY_B:   begin op_a = sy_e;  op_b = sy_e;  end
         STEP_NS_A:   begin op_a = n_e;   op_b = sxy_e; end
         STEP_NS_B:   begin op_a = sx_e;  op_b = sy_e;  end
         STEP_NI_A:   begin op_a = sxx_e; op_b = sy_e;  end
         STEP_NI_B:   begin op_a = sx_e;  op_b = sxy_e; end
         STEP_R2_NUM: begin op_a = ns_ff; op_b = ns_ff; end
         STEP_R2_DEN: begin op_a = dx_ff; op_b = dy_ff; end
         default:     begin op_a = '0;    op_b = '0;    end
      endcase
   end

   assign mag_a    = op_a[OPER_W-1] ? OPER_W'(-op_a) : op_a;
   assign mag_b    = op_b[OPER_W-1] ? OPER_W'(-op_b) : op_b;
   assign prod_neg = op_a[OPER_W-1] ^ op_b[OPER_W-1];
   assign load     = (cmd.step == STEP_DX_A) || (cmd.step == STEP_DY_A) ||
                     (cmd.step == STEP_NS_A) || (cmd.step == STEP_NI_A);
   assign p64      = prod_neg ? (OPER_W'(0) - product[OPER_W-1:0]) : product[OPER_W-1:0];

   lslf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .opa     (mag_a),
      .opb     (mag_b),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      div_num = r2num_ff;
      div_den = r2den_ff;
      case (cmd.step)
         STEP_DIV_SLOPE: begin
            div_num = WIDE_W'(ns_ff[OPER_W-1] ? OPER_W'(-ns_ff) : ns_ff);
            div_den = WIDE_W'(dx_ff);
         end
         STEP_DIV_ICPT: begin
            div_num = WIDE_W'(ni_ff[OPER_W-1] ? OPER_W'(-ni_ff) : ni_ff);
            div_den = WIDE_W'(dx_ff);
         end
         default: begin
            div_num = r2num_ff;
            div_den = r2den_ff;
         end
      endcase
   end

   // Round to nearest, ties away from zero: (num * 2^17 + den) / (2 * den).
   assign dividend = (div_num << FRAC_SHIFT) + div_den;
   assign divisor  = div_den << 1;

   lslf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (cmd.step)
            STEP_DX_A, STEP_DX_B: dx_ff <= load ? p64 : dx_ff - p64;
            STEP_DY_A, STEP_DY_B: dy_ff <= load ? p64 : dy_ff - p64;
            STEP_NS_A, STEP_NS_B: ns_ff <= load ? p64 : ns_ff - p64;
            STEP_NI_A, STEP_NI_B: ni_ff <= load ? p64 : ni_ff - p64;
            STEP_R2_NUM:          r2num_ff <= product;
            STEP_R2_DEN:          r2den_ff <= product;
            default:              ;
         endcase
      end
      if (div_done) begin
         case (cmd.step)
            STEP_DIV_SLOPE: slope_ff <= q16_sat(quotient, ns_ff[OPER_W-1]);
            STEP_DIV_ICPT:  icpt_ff  <= q16_sat(quotient, ni_ff[OPER_W-1]);
            STEP_DIV_R2:    r2_ff    <= (quotient > WIDE_W'(RSQ_ONE)) ? RSQ_ONE
                                                                      : quotient[16:0];
            default:        ;
         endcase
      end
   end

   assign x_flat = (dx_ff == '0) || dx_ff[OPER_W-1];
   assign y_flat = (dy_ff == '0) || dy_ff[OPER_W-1];

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (x_flat) begin
            out_slope_ff  <= SLOPE_ONE;
            out_icpt_ff   <= '0;
            out_r2_ff     <= '0;
         end else begin
            out_slope_ff  <= slope_ff;
            out_icpt_ff   <= icpt_ff;
            out_r2_ff     <= y_flat ? 17'd0 : r2_ff;
         end
         if (ovf_ff) begin
            out_status_ff <= STATUS_OVERFLOW;
         end else if (x_flat) begin
            out_status_ff <= STATUS_X_FLAT;
         end else begin
            out_status_ff <= y_flat ? STATUS_Y_FLAT : STATUS_OK;
         end
      end
   end

   assign stat.mul_done = mul_done;
   assign stat.div_done = div_done;
   assign rsp_slope     = out_slope_ff;
   assign rsp_intercept = out_icpt_ff;
   assign rsp_r_squared = out_r2_ff;
   assign rsp_status    = out_status_ff;

endmodule

// ----- rtl/lslf_ctrl.sv -----
// Sequencer that steps the shared multiplier and divider through the fit.
module lslf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last_point,
   input  lslf_pkg::stat_type stat,
   output lslf_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import lslf_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} ctrl_state_type;

   ctrl_state_type state_ff;
   step_type       step_ff;
   logic           valid_ff;
   logic           is_div;
   logic           unit_done;

   assign is_div    = step_ff >= STEP_DIV_SLOPE;
   assign unit_done = is_div ? stat.div_done : stat.mul_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_DX_A;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start && req_last_point) begin
                  state_ff <= ST_ISSUE;
                  step_ff  <= STEP_DX_A;
               end
            end
            ST_ISSUE: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (unit_done) begin
                  if (step_ff == STEP_DIV_R2) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     step_ff  <= step_type'(step_ff + 1'b1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
               valid_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign cmd.take   = start && (state_ff == ST_IDLE);
   assign cmd.mul_go = (state_ff == ST_ISSUE) && !is_div;
   assign cmd.div_go = (state_ff == ST_ISSUE) && is_div;
   assign cmd.finish = state_ff == ST_FINISH;
   assign cmd.step   = step_ff;
   assign rsp_valid  = valid_ff;

endmodule

// ----- rtl/least_squares_line_fit_core.sv -----
// Top level of the least-squares line-fit core.
//
//   channel   ports                               transfer
//   request   req_x, req_y, req_last_point        start high while busy low
//   response  rsp_slope, rsp_intercept,           rsp_valid high for one cycle
//             rsp_r_squared, rsp_status
//
// Points are taken one per clock while busy is low.
// The point marked last raises busy for the fit: ten products on a bit-serial
// multiplier and three bit-serial divisions, after which the result strobes
// for one cycle. The next set may start in the cycle the result is shown.
// Reset clears the sums and the sequencer; the receiver cannot stall.
module least_squares_line_fit_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_x,
   input  logic signed [15:0] req_y,
   input  logic               req_last_point,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_slope,
   output logic signed [31:0] rsp_intercept,
   output logic [16:0]        rsp_r_squared,
   output logic [1:0]         rsp_status
);
   import lslf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lslf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last_point (req_last_point),
      .stat           (stat),
      .cmd            (cmd),
      .busy           (busy),
      .rsp_valid      (rsp_valid)
   );

   lslf_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_x         (req_x),
      .req_y         (req_y),
      .rsp_slope     (rsp_slope),
      .rsp_intercept (rsp_intercept),
      .rsp_r_squared (rsp_r_squared),
      .rsp_status    (rsp_status)
   );

`ifndef NO_ASSERTIONS
   // A last point must start the fit.
   a_fit_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_point) |=> busy)
      else $error("fit did not start after last point");

   // The fit is long, so two result strobes never touch.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // A flat x set always reports the fixed fallback line.
   a_flat_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_X_FLAT) |->
         (rsp_slope == SLOPE_ONE && rsp_intercept == 32'd0 && rsp_r_squared == 17'd0))
      else $error("flat x result is not the fallback line");
`endif

endmodule

// ----- tb/sv/least_squares_line_fit_core_test.sv -----
// Self-checking testbench for the least-squares line-fit core: point sets in, fits compared.
module least_squares_line_fit_core_test;
   import lslf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_GAP        = 6;

   typedef struct {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic [16:0]        r_squared;
      logic [1:0]         status;
   } line_fit_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_x = '0;
   logic signed [15:0] req_y = '0;
   logic               req_last_point = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_slope;
   logic signed [31:0] rsp_intercept;
   logic [16:0]        rsp_r_squared;
   logic [1:0]         rsp_status;

   line_fit_type fit_queue[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;

   // Running sums mirrored from the block.
   int      kept_points = 0;
   longint  acc_x = 0, acc_y = 0, acc_xx = 0, acc_yy = 0, acc_xy = 0;
   bit      points_dropped = 0;

   least_squares_line_fit_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x(req_x), .req_y(req_y), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_slope(rsp_slope), .rsp_intercept(rsp_intercept),
      .rsp_r_squared(rsp_r_squared), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(num * 2^16 / den), ties away from zero, on magnitudes.
   function automatic logic [191:0] rounded_quotient(logic [191:0] num, logic [191:0] den);
      return ((num << 17) + den) / (den << 1);
   endfunction

   function automatic logic [31:0] saturated_q16(logic signed [191:0] num,
                                                logic [191:0] den);
      logic [191:0] q;
      q = rounded_quotient(num < 0 ? -num : num, den);
      if (num >= 0) return (q > 192'h7FFF_FFFF) ? Q16_MAX : q[31:0];
      return (q > 192'h8000_0000) ? Q16_MIN : (32'd0 - q[31:0]);
   endfunction

   task automatic fit_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      logic signed [191:0] n, sx, sy, sxx, syy, sxy, dx, dy, ns, ni;
      logic [191:0]        q;
      line_fit_type        fit;
      if (kept_points < MAX_POINTS) begin
         kept_points++;
         acc_x  += x;
         acc_y  += y;
         acc_xx += longint'(x) * x;
         acc_yy += longint'(y) * y;
         acc_xy += longint'(x) * y;
      end else begin
         points_dropped = 1;
      end
      if (!last) return;
      n = kept_points; sx = acc_x; sy = acc_y;
      sxx = acc_xx; syy = acc_yy; sxy = acc_xy;
      dx = n * sxx - sx * sx;
      dy = n * syy - sy * sy;
      ns = n * sxy - sx * sy;
      ni = sxx * sy - sx * sxy;
      fit.r_squared = '0;
      if (dx <= 0) begin
         fit.slope = SLOPE_ONE;
         fit.intercept = '0;
         fit.status = STATUS_X_FLAT;
      end else begin
         fit.slope = saturated_q16(ns, dx);
         fit.intercept = saturated_q16(ni, dx);
         if (dy <= 0) begin
            fit.status = STATUS_Y_FLAT;
         end else begin
            q = rounded_quotient(ns * ns, dx * dy);
            fit.r_squared = (q > 192'h1_0000) ? RSQ_ONE : q[16:0];
            fit.status = STATUS_OK;
         end
      end
      if (points_dropped) fit.status = STATUS_OVERFLOW;
      fit_queue.insert(fit_queue.size(), fit);
      kept_points = 0;
      acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
      points_dropped = 0;
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Called at a rising edge; returns at the edge where the point transferred, or after a random gap with start low.
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      start <= 1'b1;
      req_x <= x;
      req_y <= y;
      req_last_point <= last;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      fit_point(x, y, last);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 1)) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         end
      end
   endtask

   task automatic send_set(int count, int kind);
      logic signed [15:0] x0, y0, dys;
      x0 = 16'($urandom); y0 = 16'($urandom);
      dys = 16'($urandom_range(0, 40) - 20);
      for (int i = 0; i < count; i++) begin
         case (kind)
            0: send_point(16'($urandom), 16'($urandom), i == count - 1);
            1: send_point(16'($urandom_range(0, 200) - 100),
                          16'($urandom_range(0, 200) - 100), i == count - 1);
            2: send_point(16'(x0 + i), 16'(y0 + dys * i), i == count - 1);
            3: send_point(x0, 16'($urandom), i == count - 1);
            default: send_point(16'($urandom), y0, i == count - 1);
         endcase
      end
   endtask

   always @(posedge clock) begin
      line_fit_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else if (rsp_valid) begin
         idle_cycles <= 0;
         if (fit_queue.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = fit_queue.pop_front();
            if (rsp_slope !== want.slope) report_mismatch("slope", rsp_slope, want.slope);
            if (rsp_intercept !== want.intercept)
               report_mismatch("intercept", rsp_intercept, want.intercept);
            if (rsp_r_squared !== want.r_squared)
               report_mismatch("r_squared", rsp_r_squared, want.r_squared);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
         end
      end else if (start && !busy) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("least_squares_line_fit_core_test: errors");
            $finish;
         end
      end
   end

   task automatic test_extremes();
      send_point(16'sh8000, 16'sh7FFF, 1'b0);
      send_point(16'sh7FFF, 16'sh8000, 1'b1);
      send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh0000, 16'sh0000, 1'b1);
      // Steep lines drive slope to both saturation limits.
      send_point(0, 16'sh8000, 1'b0);
      send_point(1, 16'sh7FFF, 1'b1);
      send_point(0, 16'sh7FFF, 1'b0);
      send_point(1, 16'sh8000, 1'b1);
      // Far from the origin the intercept saturates too.
      send_point(16'sh7FFE, 16'sh8000, 1'b0);
      send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh8001, 16'sh7FFF, 1'b1);
   endtask

   task automatic test_special_cases();
      send_point(123, -45, 1'b1);          // single point has no x spread
      send_point(-7, 10, 1'b0);
      send_point(-7, 99, 1'b1);            // same x throughout
      send_point(-3, 500, 1'b0);
      send_point(9, 500, 1'b1);            // same y throughout
      send_point(1, 3, 1'b0);
      send_point(2, 5, 1'b0);
      send_point(3, 7, 1'b1);              // exact line
   endtask

   task automatic test_overflow();
      send_set(MAX_POINTS + 5, 0);
      send_set(MAX_POINTS + 1, 3);
      send_set(MAX_POINTS, 1);
   endtask

   task automatic test_random();
      int kind;
      for (int s = 0; s < 210; s++) begin
         kind = $urandom_range(0, 9);
         send_set($urandom_range(1, 9), kind < 5 ? (kind < 3 ? 0 : 1) : kind - 3);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_special_cases();
      test_overflow();
      test_random();
      start <= 1'b0;
      while (fit_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("least_squares_line_fit_core_test: clean");
      end else begin
         $display("least_squares_line_fit_core_test: errors");
      end
      $finish;
   end

endmodule
